/* sv/qslerp_pkg.sv */
// Shared constants for the quaternion slerp pipeline.
// Q.30 angle constants, arctangent table, stream widths. No dependencies.
package qslerp_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_LEN         = 24;
  localparam int CW               = 34;   // CORDIC datapath width, signed

  localparam int IN_TDATA_W  = 152;
  localparam int OUT_TDATA_W = 64;
  localparam int OUT_TUSER_W = 2;

  localparam logic [31:0] ONE_Q30     = 32'd1073741824;
  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [31:0] GAIN_Q30    = 32'd652032874;

  localparam logic [15:0] THR_RESET = 16'd66;
  localparam logic [16:0] T_ONE     = 17'd65536;

  // atan(2^-i) in Q.30 radians
  localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
    32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
    32'd33543515,  32'd16775850,  32'd8388437,   32'd4194282,   32'd2097149,
    32'd1048575,   32'd524287,    32'd262143,    32'd131071,    32'd65535,
    32'd32767,     32'd16383,     32'd8191,      32'd4095,      32'd2047,
    32'd1023,      32'd511,       32'd255,       32'd127
  };

endpackage

/* sv/quaternion_slerp_core.sv */
// Quaternion slerp. Throughput one beat per cycle while the output is not stalled; the rate
// is set by the fully pipelined sqrt, CORDIC and restoring-divider chains, one
// iteration per stage.
// The whole pipe advances together and holds while a result beat waits.
// Reset (rst_n low, synchronous) empties the pipe and sets linear_threshold to 66.
module quaternion_slerp_core #(
  parameter int CORDIC_STEPS = qslerp_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [15:0]                        cfg_wr_data,   // linear_threshold
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // start_w, start_x, start_y, start_z, end_w, end_x, end_y, end_z, fraction, pad
  input  logic [qslerp_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // res_w, res_x, res_y, res_z
  output logic [qslerp_pkg::OUT_TDATA_W-1:0] out_tdata,
  // linear_used, clipped
  output logic [qslerp_pkg::OUT_TUSER_W-1:0] out_tuser
);
  import qslerp_pkg::*;

  localparam int N         = CORDIC_STEPS;
  localparam int SQ_STEPS  = 31;   // 2 radicand bits per stage over a 61-bit value
  localparam int DIV_STEPS = 17;   // quotient bits kept before saturation
  localparam int LAT       = 64 + 2 * N;

  // payload carried alongside the front half
  typedef struct packed {
    logic [3:0][15:0] p;
    logic [3:0][15:0] q;
    logic [16:0]      t;
    logic             c_neg;
    logic [30:0]      cmag;
    logic             lin;
    logic [3:0][15:0] lres;
    logic             lclip;
  } side_t;

  // linear-path result carried through the back half
  typedef struct packed {
    logic             lin;
    logic [3:0][15:0] lres;
    logic             lclip;
  } tail_t;

  logic             en;
  logic [LAT-1:0]   vld_r;
  logic [15:0]      thr_r;

  // global advance: output register empty or being taken
  assign en         = !out_tvalid || out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      thr_r <= THR_RESET;
    end else begin
      if (en) begin
        vld_r <= {vld_r[LAT-2:0], in_tvalid};
      end
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
    end
  end

  // ---------------- s0: capture, clamp t ----------------
  side_t s0_nxt, s0_sd_r;
  always_comb begin
    s0_nxt = '0;
    for (int k = 0; k < 4; k++) begin
      s0_nxt.p[k] = in_tdata[16*k +: 16];
      s0_nxt.q[k] = in_tdata[64+16*k +: 16];
    end
    s0_nxt.t = (in_tdata[144:128] > T_ONE) ? T_ONE : in_tdata[144:128];
  end

  always_ff @(posedge clk) begin
    if (en) s0_sd_r <= s0_nxt;
  end

  // ---------------- s1: products ----------------
  side_t                   s1_sd_r;
  logic signed [31:0]      pp_r [4];
  logic signed [33:0]      la_r [4];
  logic signed [33:0]      lb_r [4];
  logic [16:0]             tc;
  assign tc = T_ONE - s0_sd_r.t;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sd_r <= s0_sd_r;
      for (int k = 0; k < 4; k++) begin
        pp_r[k] <= $signed(s0_sd_r.p[k]) * $signed(s0_sd_r.q[k]);
        la_r[k] <= $signed(s0_sd_r.p[k]) * $signed({1'b0, tc});
        lb_r[k] <= $signed(s0_sd_r.q[k]) * $signed({1'b0, s0_sd_r.t});
      end
    end
  end

  // ---------------- s2: sums ----------------
  side_t              s2_sd_r;
  logic signed [35:0] dot_r;
  logic signed [34:0] ls_r [4];
  logic signed [35:0] dot_nxt;
  assign dot_nxt = (36'(pp_r[0]) + 36'(pp_r[1]) + 36'(pp_r[2]) + 36'(pp_r[3])) <<< 2;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sd_r <= s1_sd_r;
      dot_r   <= dot_nxt;
      for (int k = 0; k < 4; k++) begin
        ls_r[k] <= 35'(la_r[k]) + 35'(lb_r[k]);
      end
    end
  end

  // ---------------- s3: path select, clamp cos, linear rounding ----------------
  side_t              s3_nxt, s3_sd_r;
  logic signed [36:0] diff;
  logic [36:0]        adiff;
  logic [34:0]        lmag [4];
  logic [34:0]        lrnd [4];
  logic [18:0]        lr   [4];

  always_comb begin
    s3_nxt = s2_sd_r;
    diff   = $signed({5'b0, ONE_Q30}) - 37'(dot_r);
    adiff  = (diff < 0) ? 37'(-diff) : 37'(diff);
    s3_nxt.lin   = adiff < {7'b0, thr_r, 14'b0};
    s3_nxt.c_neg = dot_r < 0;
    if (dot_r > $signed({4'b0, ONE_Q30}) || dot_r < -$signed({4'b0, ONE_Q30})) begin
      s3_nxt.cmag = ONE_Q30[30:0];
    end else begin
      s3_nxt.cmag = (dot_r < 0) ? 31'(-dot_r) : dot_r[30:0];
    end
    s3_nxt.lclip = 1'b0;
    for (int k = 0; k < 4; k++) begin
      lmag[k] = (ls_r[k] < 0) ? 35'(-ls_r[k]) : 35'(ls_r[k]);
      lrnd[k] = lmag[k] + 35'd32768;
      lr[k]   = lrnd[k][34:16];
      if (ls_r[k] < 0) begin
        if (lr[k] > 19'd32768) begin
          s3_nxt.lres[k] = 16'h8000;
          s3_nxt.lclip   = 1'b1;
        end else begin
          s3_nxt.lres[k] = 16'(19'd0 - lr[k]);
        end
      end else begin
        if (lr[k] > 19'd32767) begin
          s3_nxt.lres[k] = 16'h7fff;
          s3_nxt.lclip   = 1'b1;
        end else begin
          s3_nxt.lres[k] = lr[k][15:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) s3_sd_r <= s3_nxt;
  end

  // ---------------- s4: c^2, s5: radicand 1 - c^2 ----------------
  side_t       s4_sd_r, s5_sd_r;
  logic [61:0] csq_r;
  logic [60:0] rad_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_sd_r <= s3_sd_r;
      csq_r   <= 62'(s3_sd_r.cmag) * 62'(s3_sd_r.cmag);
      s5_sd_r <= s4_sd_r;
      rad_r   <= (61'(1) << 60) - csq_r[60:0];
    end
  end

  // ---------------- integer square root, one result bit per stage ----------------
  logic [60:0] sq_n_r  [SQ_STEPS];
  logic [61:0] sq_q_r  [SQ_STEPS];
  side_t       sq_sd_r [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
    logic [60:0] n_in;
    logic [61:0] q_in, bitv, sum;
    side_t       sd_in;
    if (k == 0) begin : g_src
      assign n_in  = rad_r;
      assign q_in  = '0;
      assign sd_in = s5_sd_r;
    end else begin : g_src
      assign n_in  = sq_n_r[k-1];
      assign q_in  = sq_q_r[k-1];
      assign sd_in = sq_sd_r[k-1];
    end
    assign bitv = 62'(1) << (60 - 2 * k);
    assign sum  = q_in + bitv;
    always_ff @(posedge clk) begin
      if (en) begin
        sq_sd_r[k] <= sd_in;
        if ({1'b0, n_in} >= sum) begin
          sq_n_r[k] <= n_in - sum[60:0];
          sq_q_r[k] <= (q_in >> 1) + bitv;
        end else begin
          sq_n_r[k] <= n_in;
          sq_q_r[k] <= q_in >> 1;
        end
      end
    end
  end

  // ---------------- vectoring CORDIC: atan2(sin, |cos|) ----------------
  logic signed [CW-1:0] v_x_r  [N];
  logic signed [CW-1:0] v_y_r  [N];
  logic signed [CW-1:0] v_z_r  [N];
  side_t                v_sd_r [N];

  for (genvar i = 0; i < N; i++) begin : g_vec
    logic signed [CW-1:0] x_in, y_in, z_in, atan;
    side_t                sd_in;
    if (i == 0) begin : g_src
      assign x_in  = $signed({{(CW-31){1'b0}}, sq_sd_r[SQ_STEPS-1].cmag});
      assign y_in  = $signed({{(CW-31){1'b0}}, sq_q_r[SQ_STEPS-1][30:0]});
      assign z_in  = '0;
      assign sd_in = sq_sd_r[SQ_STEPS-1];
    end else begin : g_src
      assign x_in  = v_x_r[i-1];
      assign y_in  = v_y_r[i-1];
      assign z_in  = v_z_r[i-1];
      assign sd_in = v_sd_r[i-1];
    end
    assign atan = $signed({{(CW-32){1'b0}}, ATAN_TAB[i]});
    always_ff @(posedge clk) begin
      if (en) begin
        v_sd_r[i] <= sd_in;
        if (y_in > 0) begin
          v_x_r[i] <= x_in + (y_in >>> i);
          v_y_r[i] <= y_in - (x_in >>> i);
          v_z_r[i] <= z_in + atan;
        end else begin
          v_x_r[i] <= x_in - (y_in >>> i);
          v_y_r[i] <= y_in + (x_in >>> i);
          v_z_r[i] <= z_in - atan;
        end
      end
    end
  end

  // ---------------- theta, t*theta, split angles ----------------
  side_t              th_sd_r, pr_sd_r, a_sd_r;
  logic signed [34:0] thv;
  logic [31:0]        th_r, pr_th_r, a0_r, a1_r, ath_r;
  logic [48:0]        pr_r, pr_rnd;

  always_comb begin
    if (v_sd_r[N-1].c_neg) begin
      thv = $signed({3'b0, PI_Q30}) - 35'(v_z_r[N-1]);
    end else begin
      thv = 35'(v_z_r[N-1]);
    end
  end

  assign pr_rnd = pr_r + 49'd32768;

  always_ff @(posedge clk) begin
    if (en) begin
      th_sd_r <= v_sd_r[N-1];
      if (thv < 0) begin
        th_r <= '0;
      end else if (thv > $signed({3'b0, PI_Q30})) begin
        th_r <= PI_Q30;
      end else begin
        th_r <= thv[31:0];
      end
      pr_sd_r <= th_sd_r;
      pr_th_r <= th_r;
      pr_r    <= 49'(th_sd_r.t) * 49'(th_r);
      a_sd_r  <= pr_sd_r;
      a1_r    <= pr_rnd[47:16];
      a0_r    <= pr_th_r - pr_rnd[47:16];
      ath_r   <= pr_th_r;
    end
  end

  // ---------------- three sines in parallel ----------------
  logic [30:0] s0_sin, s1_sin, st_sin;
  side_t       sn_sd_r [N+2];

  qslerp_sin #(.STEPS(N)) u_sin_a0 (.clk(clk), .en(en), .ang_i(a0_r),  .sin_o(s0_sin));
  qslerp_sin #(.STEPS(N)) u_sin_a1 (.clk(clk), .en(en), .ang_i(a1_r),  .sin_o(s1_sin));
  qslerp_sin #(.STEPS(N)) u_sin_th (.clk(clk), .en(en), .ang_i(ath_r), .sin_o(st_sin));

  always_ff @(posedge clk) begin
    if (en) begin
      sn_sd_r[0] <= a_sd_r;
      for (int j = 1; j < N + 2; j++) begin
        sn_sd_r[j] <= sn_sd_r[j-1];
      end
    end
  end

  // ---------------- numerators q0*sin(a0) + q1*sin(a1) ----------------
  tail_t              np_tl_r, ns_tl_r, nm_tl_r;
  logic signed [47:0] np_r [4];
  logic signed [47:0] nq_r [4];
  logic signed [48:0] n_r  [4];
  logic [30:0]        np_st_r, ns_st_r, nm_st_r;
  logic [3:0][46:0]   num_r;
  logic [3:0]         nm_neg_r, nm_zero_r;
  logic [48:0]        nmag [4];
  side_t              sn_last;

  assign sn_last = sn_sd_r[N+1];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      nmag[k] = (n_r[k] < 0) ? 49'(-n_r[k]) : 49'(n_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      np_tl_r <= '{lin: sn_last.lin, lres: sn_last.lres, lclip: sn_last.lclip};
      np_st_r <= st_sin;
      for (int k = 0; k < 4; k++) begin
        np_r[k] <= $signed(sn_last.p[k]) * $signed({1'b0, s0_sin});
        nq_r[k] <= $signed(sn_last.q[k]) * $signed({1'b0, s1_sin});
      end
      ns_tl_r <= np_tl_r;
      ns_st_r <= np_st_r;
      for (int k = 0; k < 4; k++) begin
        n_r[k] <= 49'(np_r[k]) + 49'(nq_r[k]);
      end
      nm_tl_r <= ns_tl_r;
      nm_st_r <= ns_st_r;
      for (int k = 0; k < 4; k++) begin
        nm_neg_r[k]  <= n_r[k] < 0;
        nm_zero_r[k] <= n_r[k] == 0;
        num_r[k]     <= nmag[k][46:0] + 47'(ns_st_r >> 1);
      end
    end
  end

  // ---------------- restoring divider, overflow check then one bit per stage ----------------
  tail_t            dc_tl_r;
  logic [30:0]      dc_st_r;
  logic [3:0]       dc_neg_r, dc_zero_r, dc_ovf_r;
  logic [3:0][30:0] dc_rem_r;
  logic [3:0][16:0] dc_lo_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dc_tl_r   <= nm_tl_r;
      dc_st_r   <= nm_st_r;
      dc_neg_r  <= nm_neg_r;
      dc_zero_r <= nm_zero_r;
      for (int k = 0; k < 4; k++) begin
        dc_ovf_r[k] <= {1'b0, num_r[k][46:17]} >= nm_st_r;
        dc_rem_r[k] <= {1'b0, num_r[k][46:17]};
        dc_lo_r[k]  <= num_r[k][16:0];
      end
    end
  end

  tail_t            dv_tl_r   [DIV_STEPS];
  logic [30:0]      dv_st_r   [DIV_STEPS];
  logic [3:0]       dv_neg_r  [DIV_STEPS];
  logic [3:0]       dv_zero_r [DIV_STEPS];
  logic [3:0]       dv_ovf_r  [DIV_STEPS];
  logic [3:0][30:0] dv_rem_r  [DIV_STEPS];
  logic [3:0][16:0] dv_lo_r   [DIV_STEPS];
  logic [3:0][16:0] dv_quo_r  [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    tail_t            tl_in;
    logic [30:0]      st_in;
    logic [3:0]       neg_in, zero_in, ovf_in;
    logic [3:0][30:0] rem_in;
    logic [3:0][16:0] lo_in, quo_in;
    logic [31:0]      rs [4];
    if (j == 0) begin : g_src
      assign tl_in   = dc_tl_r;
      assign st_in   = dc_st_r;
      assign neg_in  = dc_neg_r;
      assign zero_in = dc_zero_r;
      assign ovf_in  = dc_ovf_r;
      assign rem_in  = dc_rem_r;
      assign lo_in   = dc_lo_r;
      assign quo_in  = '0;
    end else begin : g_src
      assign tl_in   = dv_tl_r[j-1];
      assign st_in   = dv_st_r[j-1];
      assign neg_in  = dv_neg_r[j-1];
      assign zero_in = dv_zero_r[j-1];
      assign ovf_in  = dv_ovf_r[j-1];
      assign rem_in  = dv_rem_r[j-1];
      assign lo_in   = dv_lo_r[j-1];
      assign quo_in  = dv_quo_r[j-1];
    end
    always_comb begin
      for (int k = 0; k < 4; k++) begin
        rs[k] = {rem_in[k], lo_in[k][DIV_STEPS-1-j]};
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_tl_r[j]   <= tl_in;
        dv_st_r[j]   <= st_in;
        dv_neg_r[j]  <= neg_in;
        dv_zero_r[j] <= zero_in;
        dv_ovf_r[j]  <= ovf_in;
        dv_lo_r[j]   <= lo_in;
        for (int k = 0; k < 4; k++) begin
          if (rs[k] >= {1'b0, st_in}) begin
            dv_rem_r[j][k] <= 31'(rs[k] - {1'b0, st_in});
            dv_quo_r[j][k] <= {quo_in[k][15:0], 1'b1};
          end else begin
            dv_rem_r[j][k] <= rs[k][30:0];
            dv_quo_r[j][k] <= {quo_in[k][15:0], 1'b0};
          end
        end
      end
    end
  end

  // ---------------- saturate, pick path, output register ----------------
  localparam int DL = DIV_STEPS - 1;

  logic [3:0][15:0] sres;
  logic             sclip;
  logic [63:0]      out_data_r;
  logic [1:0]       out_user_r;
  tail_t            fin_tl;

  assign fin_tl = dv_tl_r[DL];

  always_comb begin
    sclip = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (dv_zero_r[DL][k]) begin
        sres[k] = '0;
      end else if (dv_ovf_r[DL][k]) begin
        // includes the zero divisor case
        sres[k] = dv_neg_r[DL][k] ? 16'h8000 : 16'h7fff;
        sclip   = 1'b1;
      end else if (dv_neg_r[DL][k]) begin
        if (dv_quo_r[DL][k] > 17'd32768) begin
          sres[k] = 16'h8000;
          sclip   = 1'b1;
        end else begin
          sres[k] = 16'(17'd0 - dv_quo_r[DL][k]);
        end
      end else begin
        if (dv_quo_r[DL][k] > 17'd32767) begin
          sres[k] = 16'h7fff;
          sclip   = 1'b1;
        end else begin
          sres[k] = dv_quo_r[DL][k][15:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= fin_tl.lin ? fin_tl.lres : sres;
      out_user_r <= {fin_tl.lin ? fin_tl.lclip : sclip, fin_tl.lin};
    end
  end

  assign out_tdata = out_data_r;
  assign out_tuser = out_user_r;

  // ---------------- assertions ----------------
  a_reset_empty : assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("pipe not empty after reset");

  a_root_bound : assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[5 + SQ_STEPS] |-> sq_q_r[SQ_STEPS-1] <= 62'(ONE_Q30))
    else $error("sqrt result above one");

  a_div_rem : assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[LAT-2] && !dv_ovf_r[DL][0] && dv_st_r[DL] != '0)
      |-> dv_rem_r[DL][0] < dv_st_r[DL])
    else $error("divider remainder not below divisor");

endmodule

/* sv/qslerp_sin.sv */
// Pipelined rotation-mode CORDIC sine for angles in [0, pi], Q.30.
// Uses qslerp_pkg. Advances on en.
module qslerp_sin #(
  parameter int STEPS = qslerp_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] ang_i,
  output logic [30:0] sin_o
);
  import qslerp_pkg::*;

  logic signed [CW-1:0] x_r [STEPS+1];
  logic signed [CW-1:0] y_r [STEPS+1];
  logic signed [CW-1:0] z_r [STEPS+1];
  logic [31:0]          fold;
  logic [30:0]          sin_r;

  // fold to [0, pi/2]
  assign fold = (ang_i > HALF_PI_Q30) ? (PI_Q30 - ang_i) : ang_i;

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= $signed({{(CW-32){1'b0}}, GAIN_Q30});
      y_r[0] <= '0;
      z_r[0] <= $signed({{(CW-32){1'b0}}, fold});
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_it
    logic signed [CW-1:0] atan;
    assign atan = $signed({{(CW-32){1'b0}}, ATAN_TAB[i]});
    always_ff @(posedge clk) begin
      if (en) begin
        if (z_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan;
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (y_r[STEPS] < 0) begin
        sin_r <= '0;
      end else if (y_r[STEPS] > $signed({{(CW-32){1'b0}}, ONE_Q30})) begin
        sin_r <= ONE_Q30[30:0];
      end else begin
        sin_r <= y_r[STEPS][30:0];
      end
    end
  end

  assign sin_o = sin_r;

endmodule
